// ----- sv/plc_pkg.sv -----
`timescale 1ns / 1ps
package plc_pkg;
	localparam int MaxPoints = 16;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int WpW = 5;
	localparam int QuoW = 50;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic search_init;
		logic search_step;
		logic fetch;
		logic mul;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic div_done;
	} stat_t;
endpackage

// ----- sv/plc_if.sv -----
`timescale 1ns / 1ps
interface plc_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] point_index;
	logic signed [31:0] point_value;
	logic [15:0] adc_code;
	modport source (output valid, kind, point_index, point_value, adc_code, input ready);
	modport sink (input valid, kind, point_index, point_value, adc_code, output ready);
endinterface

interface plc_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] calibrated_value;
	logic        span_error;
	modport source (output valid, calibrated_value, span_error, input ready);
	modport sink (input valid, calibrated_value, span_error, output ready);
endinterface

interface plc_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/plc_ctrl.sv -----
`timescale 1ns / 1ps
module plc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            out_free,
	input  plc_pkg::stat_t  stat,
	output plc_pkg::cmd_t   cmd,
	output logic            busy
);
	plc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= plc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			plc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.search_init = 1'b1;
					state_d = plc_pkg::ST_SEARCH;
				end
			end
			plc_pkg::ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.search_done) state_d = plc_pkg::ST_FETCH;
			end
			plc_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = plc_pkg::ST_MUL;
			end
			plc_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = plc_pkg::ST_DIV;
			end
			plc_pkg::ST_DIV: begin
				cmd.div_init = 1'b1;
				state_d = plc_pkg::ST_DONE;
			end
			plc_pkg::ST_DONE: begin
				cmd.div_step = 1'b1;
				if (stat.div_done && out_free) begin
					cmd.finish = 1'b1;
					state_d = plc_pkg::ST_IDLE;
				end
			end
			default: state_d = plc_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- sv/plc_dp.sv -----
`timescale 1ns / 1ps
module plc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [plc_pkg::IdxW-1:0] wr_idx,
	input  logic signed [31:0]  wr_value,
	input  logic [15:0]         wr_code,
	input  logic                ld_sample,
	input  logic [15:0]         sample,
	input  logic [4:0]          wp,
	input  plc_pkg::cmd_t       cmd,
	output plc_pkg::stat_t      stat,
	output logic signed [31:0]  res,
	output logic                err
);
	logic signed [31:0] vtab [plc_pkg::MaxPoints];
	logic [15:0] ctab [plc_pkg::MaxPoints];
	logic [15:0] x_q;
	logic [plc_pkg::IdxW-1:0] i_q, hi_q;
	logic found_q;
	logic [15:0] a_lo_q, a_hi_q;
	logic signed [31:0] v_lo_q, v_hi_q;
	logic signed [49:0] prod_q;
	logic [48:0] rem_q, quo_q;
	logic [48:0] num_abs;
	logic neg_q, zero_q;
	logic [5:0] cnt_q;
	logic [16:0] dsr_q;
	logic [49:0] trial;
	logic signed [50:0] sum;
	logic [plc_pkg::IdxW-1:0] last_idx;

	assign last_idx = plc_pkg::IdxW'(wp - 5'd1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtab[wr_idx] <= wr_value;
			ctab[wr_idx] <= wr_code;
		end
		if (ld_sample) x_q <= sample;
	end

	// linear search, one entry a cycle
	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			i_q <= '0;
			found_q <= 1'b0;
			hi_q <= last_idx;
		end else if (cmd.search_step && !found_q) begin
			if (x_q < ctab[i_q]) begin
				found_q <= 1'b1;
				hi_q <= (i_q == '0) ? plc_pkg::IdxW'(1) : i_q;
			end else if (i_q == last_idx) begin
				found_q <= 1'b1;
			end
			i_q <= i_q + 1'b1;
		end
	end
	assign stat.search_done = found_q;

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			a_lo_q <= ctab[hi_q - 1'b1];
			a_hi_q <= ctab[hi_q];
			v_lo_q <= vtab[hi_q - 1'b1];
			v_hi_q <= vtab[hi_q];
		end
		if (cmd.mul) begin
			prod_q <= $signed({1'b0, x_q} - {1'b0, a_lo_q}) *
				($signed({v_hi_q[31], v_hi_q}) - $signed({v_lo_q[31], v_lo_q}));
			dsr_q <= {1'b0, a_hi_q} - {1'b0, a_lo_q};
			zero_q <= (a_hi_q == a_lo_q);
		end
	end

	// restoring divide on magnitudes, one quotient bit a cycle
	assign num_abs = 49'(prod_q[49] ? -prod_q : prod_q);
	assign trial = {rem_q, quo_q[48]} - {33'd0, dsr_q[15:0] == 16'd0 ? 17'd0 : dsr_q[16] ? -dsr_q : dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.div_init) cnt_q <= 6'd49;
		else if (cmd.div_step && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= num_abs;
			neg_q <= prod_q[49] ^ dsr_q[16];
		end else if (cmd.div_step && cnt_q != '0) begin
			if (!trial[49]) begin
				rem_q <= trial[48:0];
				quo_q <= {quo_q[47:0], 1'b1};
			end else begin
				rem_q <= {rem_q[47:0], quo_q[48]};
				quo_q <= {quo_q[47:0], 1'b0};
			end
		end
	end
	assign stat.div_done = (cnt_q == '0);

	assign sum = 51'(v_lo_q) + (neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q}));

	always_comb begin
		err = zero_q;
		if (zero_q) res = '0;
		else if (sum > 51'sd2147483647) res = 32'sh7fffffff;
		else if (sum < -51'sd2147483648) res = 32'sh80000000;
		else res = sum[31:0];
	end
endmodule

// ----- sv/piecewise_linear_calibration_unit.sv -----
`timescale 1ns / 1ps
// Piecewise-linear calibration over up to 16 points. A point write gives no
// result. A convert goes from request to result through the sequential segment
// search over up to N table entries, a state to see the search end, the fetch,
// multiply and divider load states, 49 bit-serial divider steps and the load
// of the result register. The last step waits while the result register is
// still full, and the next request is taken after the result is loaded, once
// the unit is back in idle.
module piecewise_linear_calibration_unit (
	input logic    clk,
	input logic    arst_n,
	plc_in_if.sink   in_ch,
	plc_out_if.source out_ch,
	plc_cfg_if.sink  cfg
);
	logic [4:0] wp_q;
	logic busy, start, out_free;
	plc_pkg::cmd_t cmd;
	plc_pkg::stat_t stat;
	logic signed [31:0] res;
	logic err;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wp_q <= 5'(plc_pkg::MaxPoints);
		else if (cfg.valid) begin
			if (cfg.data < 5'd2 || 32'(cfg.data) >= plc_pkg::MaxPoints)
				wp_q <= 5'(plc_pkg::MaxPoints);
			else wp_q <= cfg.data;
		end
	end

	assign out_free = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = !busy;
	assign start = in_ch.valid && !busy && in_ch.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (cmd.finish) out_ch.valid <= 1'b1;
		else if (out_ch.ready) out_ch.valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_ch.calibrated_value <= res;
			out_ch.span_error <= err;
		end
	end

	plc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .out_free(out_free),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	plc_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.wr_en(in_ch.valid && !busy && !in_ch.kind &&
			in_ch.point_index < 16'(plc_pkg::MaxPoints)),
		.wr_idx(in_ch.point_index[plc_pkg::IdxW-1:0]),
		.wr_value(in_ch.point_value), .wr_code(in_ch.adc_code),
		.ld_sample(start), .sample(in_ch.adc_code), .wp(wp_q),
		.cmd(cmd), .stat(stat), .res(res), .err(err)
	);
endmodule

// ----- test/piecewise_linear_calibration_unit_tb.sv -----
`timescale 1ns / 1ps
module piecewise_linear_calibration_unit_tb;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CONVERT = 1'b1;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 80;

	typedef struct packed {
		logic        kind;
		logic [15:0] point_index;
		logic signed [31:0] point_value;
		logic [15:0] adc_code;
	} request_t;

	typedef struct packed {
		logic signed [31:0] calibrated_value;
		logic        span_error;
	} reading_t;

	typedef struct {
		request_t req;
		logic     has_golden;
		reading_t golden;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plc_in_if in_ch();
	plc_out_if out_ch();
	plc_cfg_if cfg();

	piecewise_linear_calibration_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the calibration state
	logic signed [31:0] val_tbl [plc_pkg::MaxPoints];
	logic [15:0] code_tbl [plc_pkg::MaxPoints];
	int active_points = plc_pkg::MaxPoints;

	reading_t pending_readings[$];
	int errors = 0;
	int idle_cycles = 0;
	bit long_stall = 0;

	task automatic report(input string what, input reading_t got, input reading_t want);
		errors++;
		$display("error %s: value %0d err %0b, wanted value %0d err %0b",
			what, got.calibrated_value, got.span_error,
			want.calibrated_value, want.span_error);
	endtask

	function automatic logic [4:0] clamp_points(input logic [4:0] raw);
		if (raw < 2 || raw >= plc_pkg::MaxPoints) return 5'(plc_pkg::MaxPoints);
		return raw;
	endfunction

	function automatic reading_t calibrate(input logic [15:0] sample);
		reading_t r;
		int hi;
		longint span, num, res;
		hi = active_points - 1;
		if (sample < code_tbl[0]) hi = 1;
		else begin
			for (int i = 1; i < active_points; i++) begin
				if (sample < code_tbl[i]) begin
					hi = i;
					break;
				end
			end
		end
		span = longint'(code_tbl[hi]) - longint'(code_tbl[hi-1]);
		if (span == 0) begin
			r.calibrated_value = '0;
			r.span_error = 1'b1;
			return r;
		end
		num = (longint'(sample) - longint'(code_tbl[hi-1]))
			* (longint'(val_tbl[hi]) - longint'(val_tbl[hi-1]));
		res = longint'(val_tbl[hi-1]) + num / span;
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		r.calibrated_value = res[31:0];
		r.span_error = 1'b0;
		return r;
	endfunction

	// sender side; valid stays up into the next request when there is no gap
	task automatic send(input request_t req);
		int gap;
		bit hs;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= req.kind;
		in_ch.point_index <= req.point_index;
		in_ch.point_value <= req.point_value;
		in_ch.adc_code <= req.adc_code;
		// ready is looked at mid-cycle, where it is settled
		do begin
			@(negedge clk);
			hs = in_ch.ready;
			@(posedge clk);
		end while (!hs);
		if (req.kind == OP_WRITE) begin
			if (req.point_index < plc_pkg::MaxPoints) begin
				val_tbl[req.point_index[plc_pkg::IdxW-1:0]] = req.point_value;
				code_tbl[req.point_index[plc_pkg::IdxW-1:0]] = req.adc_code;
			end
		end else
			pending_readings.push_back(calibrate(req.adc_code));
	endtask

	task automatic set_points(input logic [4:0] raw);
		in_ch.valid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= raw;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		active_points = clamp_points(raw);
	endtask

	task automatic write_point(input int idx, input int code, input int value);
		request_t r;
		r.kind = OP_WRITE;
		r.point_index = 16'(idx);
		r.point_value = value;
		r.adc_code = 16'(code);
		send(r);
	endtask

	task automatic convert(input logic [15:0] sample);
		request_t r;
		r.kind = OP_CONVERT;
		r.point_index = 16'($urandom);
		r.point_value = 32'($urandom);
		r.adc_code = sample;
		send(r);
	endtask

	// random non-descending table with random content
	task automatic load_table(input int npts);
		int code;
		code = $urandom_range(0, 2000);
		for (int i = 0; i < npts; i++) begin
			if ($urandom_range(0, 9) == 0 && i > 0) code = code;
			else code = code + $urandom_range(1, 65535 / (npts + 1));
			if (code > 65535) code = 65535;
			case ($urandom_range(0, 3))
				0: write_point(i, code, 32'h7fffffff - $urandom_range(0, 3));
				1: write_point(i, code, 32'h80000000 + $urandom_range(0, 3));
				default: write_point(i, code, $urandom);
			endcase
		end
	endtask

	// receiver side
	initial begin
		int wait_n;
		bit hs;
		reading_t got;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_stall = 0;
			end
			wait_n = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) wait_n = 0;
			if (wait_n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				hs = out_ch.valid;
				got.calibrated_value = out_ch.calibrated_value;
				got.span_error = out_ch.span_error;
				@(posedge clk);
			end while (!hs);
			if (pending_readings.size() == 0)
				report("unexpected result", got, got);
			else begin
				reading_t want;
				want = pending_readings.pop_front();
				if (got !== want) report("result", got, want);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("piecewise_linear_calibration_unit: mismatch");
			$finish;
		end
	end

	row_t rows[$];

	initial begin
		int count;
		reading_t want;
		in_ch.valid <= 1'b0;
		in_ch.kind <= OP_WRITE;
		in_ch.point_index <= '0;
		in_ch.point_value <= '0;
		in_ch.adc_code <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two-point tables, extremes, saturation, zero span, ignored index
		rows = '{
			'{'{OP_WRITE, 16'd0, 32'sd0, 16'd0}, 0, '{0, 0}},
			'{'{OP_WRITE, 16'd1, 32'sd65536, 16'd100}, 0, '{0, 0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd0}, 1, '{32'sd0, 1'b0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd100}, 1, '{32'sd65536, 1'b0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd50}, 1, '{32'sd32768, 1'b0}},
			'{'{OP_CONVERT, 16'hffff, -32'sd1, 16'd65535}, 0, '{0, 0}},
			'{'{OP_WRITE, 16'd16, 32'sd7, 16'd5}, 0, '{0, 0}},
			'{'{OP_WRITE, 16'hffff, -32'sd1, 16'hffff}, 0, '{0, 0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd50}, 1, '{32'sd32768, 1'b0}},
			'{'{OP_WRITE, 16'd0, 32'sh80000000, 16'd10}, 0, '{0, 0}},
			'{'{OP_WRITE, 16'd1, 32'sh7fffffff, 16'd11}, 0, '{0, 0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd0}, 0, '{0, 0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd65535}, 1, '{32'sh7fffffff, 1'b0}},
			'{'{OP_WRITE, 16'd1, 32'sd5, 16'd10}, 0, '{0, 0}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd10}, 1, '{32'sd0, 1'b1}},
			'{'{OP_CONVERT, 16'd0, 32'sd0, 16'd0}, 1, '{32'sd0, 1'b1}},
			'{'{OP_WRITE, 16'd15, 32'sd0, 16'hffff}, 0, '{0, 0}}
		};

		set_points(5'd2);
		foreach (rows[i]) begin
			send(rows[i].req);
			if (rows[i].has_golden && rows[i].req.kind == OP_CONVERT) begin
				want = pending_readings[pending_readings.size()-1];
				if (want !== rows[i].golden) report("table row", want, rows[i].golden);
			end
		end

		// random phases over random point settings, including the out-of-range ones
		count = 0;
		while (count < 1900) begin
			logic [4:0] raw;
			int n;
			case ($urandom_range(0, 5))
				0: raw = 5'd0;
				1: raw = 5'd31;
				2: raw = 5'd15;
				3: raw = 5'd2;
				default: raw = 5'($urandom);
			endcase
			set_points(raw);
			n = active_points;
			load_table(n);
			count += n;
			if (count > 900 && count < 1000) long_stall = 1;
			repeat ($urandom_range(20, 60)) begin
				int pick;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					write_point($urandom_range(plc_pkg::MaxPoints, 65535), $urandom, $urandom);
				else if (pick == 1)
					convert(code_tbl[$urandom_range(0, n - 1)]);
				else
					convert(16'($urandom));
				count++;
			end
		end

		in_ch.valid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("piecewise_linear_calibration_unit: match");
		else
			$display("piecewise_linear_calibration_unit: mismatch");
		$finish;
	end
endmodule
